/* rtl/btla_pkg.sv */
// ----------------------------------------------------------------------------
// Bakery ticket lock arbiter package
// Widths, command and status codes and the scan result type that the modules share.
// ----------------------------------------------------------------------------
package btla_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int TICKET_W  = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int CFG_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int CMD_W     = 1;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REPEAT   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_SLOTS);

  typedef struct packed {
    logic [TICKET_W-1:0] top;
    logic [TICKET_W-1:0] own;
    logic                found;
    logic [TICKET_W-1:0] best;
    logic [SLOT_W-1:0]   who;
  } btla_scan_t;

endpackage

/* rtl/btla_ifs.sv */
// ----------------------------------------------------------------------------
// Bakery ticket lock arbiter channels
// Valid/ready interfaces for the request, result and configuration channels.
// ----------------------------------------------------------------------------
interface btla_in_if;
  logic                           valid;
  logic                           ready;
  logic [btla_pkg::CMD_W-1:0]     command;
  logic [btla_pkg::SLOT_W-1:0]    slot_id;

  modport source (output valid, output command, output slot_id, input ready);
  modport sink (input valid, input command, input slot_id, output ready);
endinterface

interface btla_out_if;
  logic                           valid;
  logic                           ready;
  logic [btla_pkg::STATUS_W-1:0]  status;
  logic [btla_pkg::TICKET_W-1:0]  ticket_given;
  logic                           holder_valid;
  logic [btla_pkg::SLOT_W-1:0]    holder_slot;

  modport source (output valid, output status, output ticket_given,
                  output holder_valid, output holder_slot, input ready);
  modport sink (input valid, input status, input ticket_given,
                input holder_valid, input holder_slot, output ready);
endinterface

interface btla_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [btla_pkg::CFG_W-1:0]     active_slots;

  modport source (output valid, output active_slots, input ready);
  modport sink (input valid, input active_slots, output ready);
endinterface

/* rtl/btla_ticket_mem.sv */
// ----------------------------------------------------------------------------
// Ticket store
// Synchronous memory of one ticket per slot with a registered read port; per-entry
// valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module btla_ticket_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [btla_pkg::SLOT_W-1:0]     rd_addr,
  output logic [btla_pkg::TICKET_W-1:0]   rd_data,
  input  logic                            wr_en,
  input  logic [btla_pkg::SLOT_W-1:0]     wr_addr,
  input  logic [btla_pkg::TICKET_W-1:0]   wr_data
);

  logic [btla_pkg::TICKET_W-1:0]  mem [btla_pkg::MAX_SLOTS];
  logic [btla_pkg::MAX_SLOTS-1:0] valid_r;
  logic [btla_pkg::TICKET_W-1:0]  rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/btla_scan.sv */
// ----------------------------------------------------------------------------
// Ticket scan accumulator
// Folds one read ticket per cycle while acc_en is high into the running maximum, the
// requester's own ticket and the smallest nonzero ticket of the other slots.
// ----------------------------------------------------------------------------
module btla_scan (
  input  logic                            clk,
  input  logic                            clear,
  input  logic                            acc_en,
  input  logic [btla_pkg::SLOT_W-1:0]     acc_idx,
  input  logic [btla_pkg::TICKET_W-1:0]   acc_data,
  input  logic [btla_pkg::SLOT_W-1:0]     slot,
  output btla_pkg::btla_scan_t            result
);

  btla_pkg::btla_scan_t acc_r;
  btla_pkg::btla_scan_t acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (acc_en) begin
      if (acc_data > acc_r.top) begin
        acc_nxt.top = acc_data;
      end
      if (acc_idx == slot) begin
        acc_nxt.own = acc_data;
      end else if (acc_data != '0 && (!acc_r.found || acc_data < acc_r.best)) begin
        acc_nxt.found = 1'b1;
        acc_nxt.best  = acc_data;
        acc_nxt.who   = acc_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign result = acc_r;

endmodule

/* rtl/bakery_ticket_lock_arbiter.sv */
// ----------------------------------------------------------------------------
// Bakery ticket lock arbiter
// One request per pass: a scan over the active slots, then one write-back.
// Steps: accept, scan reading each active slot once, drain, then write-back, which
//   waits while a stalled result is still held. A new request is taken only in idle,
//   after write-back; the scan reads through the single read port of the ticket store.
// Reset: synchronous; all tickets read as zero, active slot count returns to 16.
// ----------------------------------------------------------------------------
module bakery_ticket_lock_arbiter (
  input  logic              clk,
  input  logic              rst_n,
  btla_in_if.sink           in_req,
  btla_out_if.source        out_rsp,
  btla_cfg_if.sink          cfg_wr
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WB    = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [btla_pkg::CFG_W-1:0]       active_r;
  logic [btla_pkg::CNT_W-1:0]       lim;
  logic [btla_pkg::CNT_W-1:0]       cnt_r;
  logic [btla_pkg::SLOT_W-1:0]      rd_idx_r;
  logic                             rd_vld_r;
  logic [btla_pkg::CMD_W-1:0]       cmd_r;
  logic [btla_pkg::SLOT_W-1:0]      slot_r;
  logic                             accept;
  logic                             issue;
  logic                             go;
  logic [btla_pkg::TICKET_W-1:0]    rd_data;
  btla_pkg::btla_scan_t             scan;

  logic                             slot_ok;
  logic [btla_pkg::STATUS_W-1:0]    status;
  logic [btla_pkg::TICKET_W-1:0]    given;
  logic [btla_pkg::TICKET_W-1:0]    new_tkt;
  logic                             wr_en;
  logic                             hold_vld;
  logic [btla_pkg::SLOT_W-1:0]      hold_slot;

  logic                             out_valid_r;
  logic [btla_pkg::STATUS_W-1:0]    out_status_r;
  logic [btla_pkg::TICKET_W-1:0]    out_given_r;
  logic                             out_hvld_r;
  logic [btla_pkg::SLOT_W-1:0]      out_hslot_r;

  assign lim = (active_r > btla_pkg::CFG_W'(btla_pkg::MAX_SLOTS)) ?
               btla_pkg::CNT_W'(btla_pkg::MAX_SLOTS) : btla_pkg::CNT_W'(active_r);

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign issue        = (state_r == ST_SCAN) && (cnt_r < lim);
  assign go           = !out_valid_r || out_rsp.ready;

  // hold the active slot count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= btla_pkg::CFG_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      active_r <= cfg_wr.active_slots;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (!issue) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_WB;
      ST_WB:    if (go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_req.command;
      slot_r <= in_req.slot_id;
      cnt_r  <= '0;
    end else if (issue) begin
      cnt_r  <= cnt_r + 1'b1;
    end
    rd_idx_r <= cnt_r[btla_pkg::SLOT_W-1:0];
  end

  btla_ticket_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (issue),
    .rd_addr (cnt_r[btla_pkg::SLOT_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (new_tkt)
  );

  btla_scan u_scan (
    .clk      (clk),
    .clear    (accept),
    .acc_en   (rd_vld_r),
    .acc_idx  (rd_idx_r),
    .acc_data (rd_data),
    .slot     (slot_r),
    .result   (scan)
  );

  // decide the request and fold the slot's new ticket into the holder
  always_comb begin
    slot_ok   = ({1'b0, slot_r} < lim);
    status    = btla_pkg::STAT_OK;
    given     = '0;
    new_tkt   = scan.own;
    if (!slot_ok) begin
      status = btla_pkg::STAT_BAD_SLOT;
    end else if (cmd_r == btla_pkg::CMD_RELEASE) begin
      new_tkt = '0;
    end else if (scan.own != '0) begin
      status = btla_pkg::STAT_REPEAT;
    end else if (&scan.top) begin
      status = btla_pkg::STAT_OVERFLOW;
    end else begin
      given   = scan.top + 1'b1;
      new_tkt = given;
    end
    wr_en     = (state_r == ST_WB) && go && slot_ok;
    hold_vld  = scan.found;
    hold_slot = scan.found ? scan.who : '0;
    if (slot_ok && new_tkt != '0 &&
        (!scan.found || new_tkt < scan.best ||
         (new_tkt == scan.best && slot_r < scan.who))) begin
      hold_vld  = 1'b1;
      hold_slot = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_WB) && go) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_WB) && go) begin
      out_status_r <= status;
      out_given_r  <= given;
      out_hvld_r   <= hold_vld;
      out_hslot_r  <= hold_slot;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.ticket_given = out_given_r;
  assign out_rsp.holder_valid = out_hvld_r;
  assign out_rsp.holder_slot  = out_hslot_r;

endmodule

/* rtl/btla_checker.sv */
// ----------------------------------------------------------------------------
// Bakery ticket lock arbiter checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module btla_port_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [btla_pkg::STATUS_W-1:0]   out_status,
  input  logic [btla_pkg::TICKET_W-1:0]   out_ticket_given,
  input  logic                            out_holder_valid,
  input  logic [btla_pkg::SLOT_W-1:0]     out_holder_slot
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

  a_no_ticket_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != btla_pkg::STAT_OK |-> out_ticket_given == '0)
    else $error("ticket given with a failing status");

  a_issued_has_holder: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ticket_given != '0 |-> out_holder_valid)
    else $error("ticket issued but no holder reported");

  a_idle_holder_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_holder_valid |-> out_holder_slot == '0)
    else $error("holder slot nonzero without a holder");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_ticket_given) && $stable(out_holder_slot))
    else $error("stalled result changed");

endmodule

bind bakery_ticket_lock_arbiter btla_port_checker u_btla_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_ticket_given (out_rsp.ticket_given),
  .out_holder_valid (out_rsp.holder_valid),
  .out_holder_slot  (out_rsp.holder_slot)
);
